@@ rtl/core/utf16_to_utf8_transcoder_defines.svh @@
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder assertion macros
// Shared property wrappers for the transcoder RTL.
// ----------------------------------------------------------------------------
`ifndef UTF16_TO_UTF8_TRANSCODER_DEFINES_SVH
`define UTF16_TO_UTF8_TRANSCODER_DEFINES_SVH

// same-cycle implication, reset masks the check
`define UTT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("utt assertion failed");

// next-cycle implication, reset masks the check
`define UTT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("utt assertion failed");

`endif

@@ rtl/core/utt_pkg.sv @@
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder package
// Types, constants and the code point encoder shared by the transcoder RTL.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package utt_pkg;

	localparam int SIZE_W    = 16;
	localparam int UNIT_W    = 16;
	localparam int CP_W      = 21;
	localparam int MAX_BYTES = 6;
	localparam int LEN_W     = 3;

	localparam logic [5:0]      HIGH_SURR_TAG = 6'b110110;  // D800..DBFF
	localparam logic [5:0]      LOW_SURR_TAG  = 6'b110111;  // DC00..DFFF
	localparam logic [CP_W-1:0] CP_SUPP_BASE  = 21'h10000;
	localparam logic [CP_W-1:0] CP_REPLACE    = 21'h0FFFD;
	localparam logic [CP_W-1:0] CP_MAX_1B     = 21'h0007F;
	localparam logic [CP_W-1:0] CP_MAX_2B     = 21'h007FF;
	localparam logic [CP_W-1:0] CP_MAX_3B     = 21'h0FFFF;
	localparam logic [SIZE_W-1:0] SIZE_RESET  = 16'd192;

	// surrogate tracking carried between items
	typedef struct packed {
		logic       held_valid;
		logic [9:0] held_high;
		logic       stopped;
	} hold_t;

	// one code point as UTF-8, byte 0 goes out first
	typedef struct packed {
		logic [3:0][7:0]  b;
		logic [LEN_W-1:0] len;
	} enc_t;

	// all bytes one input item causes
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [LEN_W-1:0]          count;
		logic                      term;
	} burst_t;

	function automatic enc_t utf8_encode(input logic [CP_W-1:0] cp);
		enc_t e;
		e.b = '0;
		if (cp <= CP_MAX_1B) begin
			e.len  = 3'd1;
			e.b[0] = cp[7:0];
		end else if (cp <= CP_MAX_2B) begin
			e.len  = 3'd2;
			e.b[0] = {3'b110, cp[10:6]};
			e.b[1] = {2'b10, cp[5:0]};
		end else if (cp <= CP_MAX_3B) begin
			e.len  = 3'd3;
			e.b[0] = {4'b1110, cp[15:12]};
			e.b[1] = {2'b10, cp[11:6]};
			e.b[2] = {2'b10, cp[5:0]};
		end else begin
			e.len  = 3'd4;
			e.b[0] = {5'b11110, cp[20:18]};
			e.b[1] = {2'b10, cp[17:12]};
			e.b[2] = {2'b10, cp[11:6]};
			e.b[3] = {2'b10, cp[5:0]};
		end
		return e;
	endfunction

endpackage

@@ rtl/core/utt_decoder.sv @@
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder decoder
// Turns one registered code unit into its UTF-8 bytes and the next state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utt_decoder #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic [utt_pkg::UNIT_W-1:0] unit,
	input  logic                       term,
	input  logic [utt_pkg::SIZE_W-1:0] buf_size,
	input  utt_pkg::hold_t             hold,
	input  logic [COUNT_WIDTH-1:0]     written,
	output utt_pkg::burst_t            burst,
	output utt_pkg::hold_t             hold_next,
	output logic [COUNT_WIDTH-1:0]     written_next
);
	import utt_pkg::*;

	localparam int CMP_W = ((COUNT_WIDTH > SIZE_W) ? COUNT_WIDTH : SIZE_W) + 4;

	logic                  is_high;
	logic                  is_low;
	logic                  a_en;
	logic [CP_W-1:0]       a_cp;
	logic                  b_en;
	logic [CP_W-1:0]       b_cp;
	logic                  hold_cur;
	enc_t                  a_enc;
	enc_t                  b_enc;
	logic [CMP_W-1:0]      sum_a;
	logic [CMP_W-1:0]      sum_b;
	logic [CMP_W-1:0]      size_x;
	logic                  fit_a;
	logic                  fit_b;
	logic                  a_ok;
	logic                  emit_a;
	logic                  emit_b;
	logic                  stop_new;
	logic [LEN_W-1:0]      na;
	logic [LEN_W-1:0]      nb;
	logic [LEN_W-1:0]      ia;
	logic [LEN_W-1:0]      ib;

	assign is_high = (unit[15:10] == HIGH_SURR_TAG);
	assign is_low  = (unit[15:10] == LOW_SURR_TAG);

	// slot A: pending surrogate resolution, slot B: the current unit
	always_comb begin
		a_en     = 1'b0;
		a_cp     = CP_REPLACE;
		b_en     = 1'b0;
		b_cp     = {{(CP_W-UNIT_W){1'b0}}, unit};
		hold_cur = 1'b0;
		if (term) begin
			a_en = hold.held_valid && !hold.stopped;
		end else if (!hold.stopped) begin
			if (hold.held_valid && is_low) begin
				a_en = 1'b1;
				a_cp = CP_SUPP_BASE + {1'b0, hold.held_high, unit[9:0]};
			end else begin
				a_en = hold.held_valid;
				if (is_high) begin
					hold_cur = 1'b1;
				end else begin
					b_en = 1'b1;
					if (is_low)
						b_cp = CP_REPLACE;
				end
			end
		end
	end

	assign a_enc = utf8_encode(a_cp);
	assign b_enc = utf8_encode(b_cp);

	assign size_x = CMP_W'(buf_size);
	assign sum_a  = CMP_W'(written) + CMP_W'(a_en ? a_enc.len : 3'd0);
	assign sum_b  = sum_a + CMP_W'(b_enc.len);
	assign fit_a  = sum_a < size_x;
	assign fit_b  = sum_b < size_x;

	assign a_ok     = !a_en || fit_a;
	assign emit_a   = a_en && fit_a;
	assign emit_b   = b_en && a_ok && fit_b;
	assign stop_new = (a_en && !fit_a) || (b_en && a_ok && !fit_b);

	assign na = emit_a ? a_enc.len : 3'd0;
	assign nb = emit_b ? b_enc.len : 3'd0;

	// pack A bytes, then B bytes; the terminator zero fills the next slot
	always_comb begin
		burst.bytes = '0;
		for (int i = 0; i < MAX_BYTES; i++) begin
			ia = LEN_W'(i);
			ib = ia - na;
			if (ia < na)
				burst.bytes[i] = a_enc.b[ia[1:0]];
			else if (ib < nb)
				burst.bytes[i] = b_enc.b[ib[1:0]];
			else
				burst.bytes[i] = 8'h00;
		end
		burst.count = na + nb + LEN_W'(term);
		burst.term  = term;
	end

	always_comb begin
		hold_next    = hold;
		written_next = written;
		if (term) begin
			hold_next    = '0;
			written_next = '0;
		end else if (!hold.stopped) begin
			hold_next.stopped    = stop_new;
			hold_next.held_valid = hold_cur && a_ok;
			hold_next.held_high  = (hold_cur && a_ok) ? unit[9:0] : 10'd0;
			written_next         = written + COUNT_WIDTH'(na) + COUNT_WIDTH'(nb);
		end
	end

endmodule

@@ rtl/core/utf16_to_utf8_transcoder.sv @@
// UTF-16 to UTF-8 transcoder. A code unit (s_tdata) or a terminator (s_tuser
// high) is taken on every cycle the decode stage can pass its bytes on; the
// decode is one registered stage, so input and output overlap fully. Bytes
// leave on m_tdata one per cycle while m_tready is high. An item makes 0 to
// 4 bytes typically, up to 6 when a dropped high surrogate turns into U+FFFD
// ahead of a 3-byte character. The single-byte
// result port sets the sustained rate. m_tlast marks the last byte of an
// item, m_tuser the terminating zero. The buffer size (written through
// cfg_*, 192 after reset) caps the string including its terminator; once a
// character does not fit, the rest of the string is dropped until the
// terminator. Write the size only while the block is idle.
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder top level
// Input register, decoder and a byte shift buffer toward the output stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "utf16_to_utf8_transcoder_defines.svh"

module utf16_to_utf8_transcoder #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [utt_pkg::SIZE_W-1:0] cfg_data,   // buffer size
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [utt_pkg::UNIT_W-1:0] s_tdata,    // [15:0] code_unit
	input  logic                       s_tuser,    // [0] is_terminator
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [7:0]                 m_tdata,    // [7:0] out_byte
	output logic                       m_tlast,    // last_of_run
	output logic                       m_tuser     // [0] string_end
);
	import utt_pkg::*;

	logic [SIZE_W-1:0]          buf_size_q;
	logic                       valid_s1;
	logic [UNIT_W-1:0]          unit_s1;
	logic                       term_s1;
	hold_t                      hold_q;
	hold_t                      hold_next;
	logic [COUNT_WIDTH-1:0]     written_q;
	logic [COUNT_WIDTH-1:0]     written_next;
	burst_t                     burst;
	logic [MAX_BYTES-1:0][7:0]  bytes_s2;
	logic [LEN_W-1:0]           cnt_s2;
	logic                       term_s2;
	logic                       out_fire;
	logic                       buf_free;
	logic                       advance;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_size_q <= SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			buf_size_q <= cfg_data;
		end
	end

	utt_decoder #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_decoder (
		.unit        (unit_s1),
		.term        (term_s1),
		.buf_size    (buf_size_q),
		.hold        (hold_q),
		.written     (written_q),
		.burst       (burst),
		.hold_next   (hold_next),
		.written_next(written_next)
	);

	assign m_tvalid = (cnt_s2 != '0);
	assign m_tdata  = bytes_s2[0];
	assign m_tlast  = (cnt_s2 == 3'd1);
	assign m_tuser  = term_s2 && (cnt_s2 == 3'd1);
	assign out_fire = m_tvalid && m_tready;

	// buffer can take a new burst when empty or handing off its last byte
	assign buf_free = (cnt_s2 == '0) || ((cnt_s2 == 3'd1) && m_tready);
	assign advance  = valid_s1 && ((burst.count == '0) || buf_free);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			unit_s1 <= s_tdata;
			term_s1 <= s_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q    <= '0;
			written_q <= '0;
		end else if (advance) begin
			hold_q    <= hold_next;
			written_q <= written_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s2 <= '0;
		end else if (advance && (burst.count != '0)) begin
			cnt_s2 <= burst.count;
		end else if (out_fire) begin
			cnt_s2 <= cnt_s2 - 3'd1;
		end
	end

	// shift the next byte down on each output transaction
	always_ff @(posedge clk) begin
		if (advance && (burst.count != '0)) begin
			bytes_s2 <= burst.bytes;
			term_s2  <= burst.term;
		end else if (out_fire) begin
			bytes_s2 <= {8'h00, bytes_s2[MAX_BYTES-1:1]};
		end
	end

	`UTT_ASSERT_IMPL(a_load_when_free, clk, arst_n, advance && (burst.count != '0), buf_free)
	`UTT_ASSERT_IMPL(a_end_is_last, clk, arst_n, m_tvalid && m_tuser, m_tlast && (m_tdata == 8'h00))
	`UTT_ASSERT_NEXT(a_term_clears, clk, arst_n, advance && term_s1, (written_q == '0) && (hold_q == '0))
	`UTT_ASSERT_IMPL(a_stopped_no_hold, clk, arst_n, hold_q.stopped, !hold_q.held_valid)

endmodule
